>>> hw/rtl/wsfc_pkg.sv
// ---------------------------------------------------------------------------
// wsfc_pkg
// Shared types and constants of the front wheel speed tachometer.
// ---------------------------------------------------------------------------
package wsfc_pkg;

  localparam int unsigned CounterBitsDef  = 16;
  localparam int unsigned OverflowBitsDef = 32;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned CapW     = 16;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned NumW     = 40;
  localparam int unsigned TmoW     = 16;
  localparam int unsigned WheelW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = NumW;

  localparam logic [NumW-1:0] NumReset = NumW'(368640000);
  localparam logic [TmoW-1:0] TmoReset = TmoW'(100);

  typedef enum logic [CmdW-1:0] {
    CmdCapture  = 2'd0,
    CmdOverflow = 2'd1,
    CmdMsTick   = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpeedNum = 1'b0,
    CfgTimeout  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

endpackage

>>> hw/rtl/wsfc_if.sv
// ---------------------------------------------------------------------------
// wsfc_if
// Valid/ready channels for requests into and results out of the tachometer.
// ---------------------------------------------------------------------------
interface wsfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [wsfc_pkg::CmdW-1:0]   command;
  logic [wsfc_pkg::ChanW-1:0]  channel;
  logic [wsfc_pkg::CapW-1:0]   capture_value;

  modport source (output valid, command, channel, capture_value, input ready);
  modport sink   (input valid, command, channel, capture_value, output ready);
endinterface

interface wsfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [wsfc_pkg::SpeedW-1:0]  speed_kmh;
  logic                         timed_out;

  modport source (output valid, speed_kmh, timed_out, input ready);
  modport sink   (input valid, speed_kmh, timed_out, output ready);
endinterface

>>> hw/rtl/wsfc_div.sv
// ---------------------------------------------------------------------------
// wsfc_div
// Restoring radix-2 divider, one quotient bit per cycle, result saturated
// to the wheel speed width.
// ---------------------------------------------------------------------------
module wsfc_div #(
  parameter int unsigned DenW = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wsfc_pkg::NumW-1:0]   num_i,
  input  logic [DenW-1:0]             den_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [wsfc_pkg::WheelW-1:0] quot_o
);
  import wsfc_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [NumW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [DenW-1:0]   rem_q;
  logic [WheelW-1:0] quot_q;
  logic              sat_q;

  logic [DenW:0]     trial;
  logic [DenW:0]     diff;
  logic              ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = ~diff[DenW];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      sat_q  <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      rem_q  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quot_q <= {quot_q[WheelW-2:0], ge};
      sat_q  <= sat_q | quot_q[WheelW-1];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : quot_q;

endmodule

>>> hw/rtl/wheel_speed_from_capture.sv
// ---------------------------------------------------------------------------
// wheel_speed_from_capture
// Front wheel tachometer: overflow-extended capture intervals, a serial
// divider for wheel speed, averaged report per capture and a ms watchdog.
// ---------------------------------------------------------------------------
//  port    | dir | handshake     | payload
//  in_i    | in  | valid/ready   | command, channel, capture_value
//  out_o   | out | valid/ready   | speed_kmh, timed_out
//  cfg_*   | in  | write enable  | cfg_idx_i, cfg_wdata_i
//
//  front capture: starts the 40-step serial divider (one quotient bit
//  per cycle); the result goes from StDiv via StEmit to the output register
//  overflow and quiet ms tick: no result, state stays idle; rear capture,
//  zero-interval capture and firing ms tick: straight to StEmit, no divide
//  requests are taken only in the idle state, one at a time
//  results sit in an output register; while it is stalled, the next result
//  waits and no request is taken until that result is loaded
//  reset clears control state and counters and loads register defaults
// ---------------------------------------------------------------------------
module wheel_speed_from_capture #(
  parameter int unsigned COUNTER_BITS  = wsfc_pkg::CounterBitsDef,
  parameter int unsigned OVERFLOW_BITS = wsfc_pkg::OverflowBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wsfc_in_if.sink                       in_i,
  wsfc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [wsfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wsfc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wsfc_pkg::*;

  localparam int unsigned TickW = COUNTER_BITS + OVERFLOW_BITS;

  state_e state_q, state_d;

  logic [NumW-1:0]          num_q;
  logic [TmoW-1:0]          tmo_q;
  logic [OVERFLOW_BITS-1:0] ovf_total_q;
  logic [COUNTER_BITS-1:0]  last_cap_q [2];
  logic [OVERFLOW_BITS-1:0] snap_q [2];
  logic [WheelW-1:0]        wspeed_q [2];
  logic [TmoW-1:0]          idle_q;
  logic                     armed_q;
  logic                     chan_q;
  logic                     pend_tmo_q;

  logic                     out_valid_q;
  logic [SpeedW-1:0]        out_speed_q;
  logic                     out_tmo_q;

  logic                     accept;
  logic                     in_ready;
  logic                     is_cap, is_ovf, is_tick, front;
  logic                     ch;
  logic [COUNTER_BITS-1:0]  cap_val;
  logic [COUNTER_BITS-1:0]  cnt_diff;
  logic                     borrow;
  logic [OVERFLOW_BITS-1:0] ovf_raw;
  logic [OVERFLOW_BITS-1:0] ovf_hi;
  logic                     ticks_ok;
  logic [TickW-1:0]         ticks;
  logic [TmoW-1:0]          idle_inc;
  logic                     fire;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [WheelW-1:0]        div_quot;
  logic                     out_load;
  logic [WheelW:0]          speed_sum;

  assign accept  = in_i.valid & in_ready;
  assign is_cap  = (cmd_e'(in_i.command) == CmdCapture);
  assign is_ovf  = (cmd_e'(in_i.command) == CmdOverflow);
  assign is_tick = (cmd_e'(in_i.command) == CmdMsTick);
  assign front   = ~in_i.channel[1];
  assign ch      = in_i.channel[0];
  assign cap_val = COUNTER_BITS'(in_i.capture_value);

  assign cnt_diff = cap_val - last_cap_q[ch];
  assign borrow   = cap_val < last_cap_q[ch];
  assign ovf_raw  = ovf_total_q - snap_q[ch];
  assign ovf_hi   = ovf_total_q - snap_q[ch] - OVERFLOW_BITS'(borrow);
  assign ticks    = {ovf_hi, cnt_diff};
  assign ticks_ok = borrow ? (ovf_raw != '0) : ((ovf_raw != '0) || (cnt_diff != '0));

  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + TmoW'(1);
  assign fire     = armed_q & (idle_inc >= tmo_q);

  assign speed_sum = {1'b0, wspeed_q[0]} + {1'b0, wspeed_q[1]};

  wsfc_div #(
    .DenW (TickW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (ticks),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (is_cap) begin
            if (front && ticks_ok) begin
              div_start = 1'b1;
              state_d   = StDiv;
            end else begin
              state_d = StEmit;
            end
          end else if (is_tick && fire) begin
            state_d = StEmit;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NumReset;
      tmo_q       <= TmoReset;
      ovf_total_q <= '0;
      last_cap_q  <= '{default: '0};
      snap_q      <= '{default: '0};
      wspeed_q    <= '{default: '0};
      idle_q      <= '0;
      armed_q     <= 1'b0;
      pend_tmo_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgSpeedNum: num_q <= cfg_wdata_i[NumW-1:0];
          CfgTimeout:  tmo_q <= cfg_wdata_i[TmoW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (is_cap) begin
          idle_q     <= '0;
          armed_q    <= 1'b1;
          pend_tmo_q <= 1'b0;
          if (front) begin
            last_cap_q[ch] <= cap_val;
            snap_q[ch]     <= ovf_total_q;
          end
        end else if (is_ovf) begin
          ovf_total_q <= ovf_total_q + OVERFLOW_BITS'(1);
        end else if (is_tick && armed_q) begin
          idle_q <= idle_inc;
          if (fire) begin
            armed_q    <= 1'b0;
            pend_tmo_q <= 1'b1;
          end
        end
      end
      if (state_q == StDiv && div_done) begin
        wspeed_q[chan_q] <= div_quot;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q <= ch;
    end
    if (out_load) begin
      out_speed_q <= pend_tmo_q ? '0 : speed_sum[WheelW:WheelW-SpeedW+1];
      out_tmo_q   <= pend_tmo_q;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.speed_kmh = out_speed_q;
  assign out_o.timed_out = out_tmo_q;

`ifndef SYNTH
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !div_busy)
    else $error("divider busy while idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider done outside divide state");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tmo_q) |-> (out_speed_q == '0))
    else $error("timeout result with nonzero speed");

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_tick && fire) |=> (!armed_q && state_q == StEmit))
    else $error("watchdog did not disarm and report");
`endif

endmodule
